// ===== hw/rtl/bti_pkg.sv =====
package bti_pkg;

  localparam int NumCurvesDef = 4;
  localparam int MaxPointsDef = 128;
  localparam int NumRegs = 4;
  localparam int XW = 17;
  localparam int YW = 14;
  localparam int CurveW = 2;
  localparam int IdxW = 7;
  localparam int CfgW = 8;
  localparam int CfgIdxW = 2;
  localparam int QDepth = 2;

  typedef enum logic {
    REQ_LOAD  = 1'b0,
    REQ_QUERY = 1'b1
  } req_t;

  typedef struct packed {
    logic            is_query;
    logic            valid_curve;
    logic [CurveW-1:0] curve;
    logic [IdxW-1:0]   point_index;
    logic [XW-1:0]     point_x;
    logic [YW-1:0]     point_y;
    logic [XW-1:0]     wavelength;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

// ===== hw/rtl/breakpoint_table_interpolator.sv =====
// Operation: a query reads its curve one pair of breakpoints at a time, from interval 0 up, until
// the wavelength falls in one; it then interpolates through a 32-step serial divider. A query
// with no such interval among its n points, or with an invalid curve, ends with out_in_range low.
// A load is written as it leaves the queue; a query holds the back end until its result, and two
// items queue ahead of it. Results are strobed for one cycle and cannot be held off.
// Synchronous active low reset clears control and the point-count registers; tables stay unset.
module breakpoint_table_interpolator #(
  parameter int NUM_CURVES = bti_pkg::NumCurvesDef,
  parameter int MAX_POINTS = bti_pkg::MaxPointsDef
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_req_type,
  input  logic [bti_pkg::CurveW-1:0]    in_curve,
  input  logic [bti_pkg::IdxW-1:0]      in_point_index,
  input  logic [bti_pkg::XW-1:0]        in_point_x,
  input  logic [bti_pkg::YW-1:0]        in_point_y,
  input  logic [bti_pkg::XW-1:0]        in_wavelength,
  output logic                          out_valid,
  output logic [bti_pkg::YW-1:0]        out_efficiency,
  output logic                          out_in_range,
  input  logic                          cfg_we,
  input  logic [bti_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [bti_pkg::CfgW-1:0]      cfg_data
);

  logic [bti_pkg::CfgW-1:0] npts_r [bti_pkg::NumRegs];
  logic           q_valid, q_pop;
  bti_pkg::item_t q_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < bti_pkg::NumRegs; k++) begin
        npts_r[k] <= '0;
      end
    end else if (cfg_we) begin
      npts_r[cfg_index] <= cfg_data;
    end
  end

  bti_front #(.NUM_CURVES(NUM_CURVES)) u_front (
    .clk, .rst_n,
    .in_start(start), .in_busy(busy),
    .in_req_type, .in_curve, .in_point_index, .in_point_x, .in_point_y,
    .in_wavelength,
    .q_valid, .q_item, .q_pop
  );

  bti_back #(.NUM_CURVES(NUM_CURVES), .MAX_POINTS(MAX_POINTS)) u_back (
    .clk, .rst_n,
    .q_valid, .q_item, .q_pop,
    .npts(npts_r),
    .out_valid, .out_efficiency, .out_in_range
  );

endmodule

// ===== hw/rtl/bti_front.sv =====
module bti_front #(
  parameter int NUM_CURVES = bti_pkg::NumCurvesDef
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_start,
  output logic                        in_busy,
  input  logic                        in_req_type,
  input  logic [bti_pkg::CurveW-1:0]  in_curve,
  input  logic [bti_pkg::IdxW-1:0]    in_point_index,
  input  logic [bti_pkg::XW-1:0]      in_point_x,
  input  logic [bti_pkg::YW-1:0]      in_point_y,
  input  logic [bti_pkg::XW-1:0]      in_wavelength,
  output logic                        q_valid,
  output bti_pkg::item_t              q_item,
  input  logic                        q_pop
);

  bti_pkg::item_t fifo_r [bti_pkg::QDepth];
  logic [0:0] wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push;
  bti_pkg::item_t it;

  assign in_busy = (cnt_r == 2'(bti_pkg::QDepth));
  assign push    = in_start && !in_busy;
  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = fifo_r[rp_r];

  always_comb begin
    it.is_query    = (in_req_type == bti_pkg::REQ_QUERY);
    it.valid_curve = ({30'd0, in_curve} < NUM_CURVES);
    it.curve       = in_curve;
    it.point_index = in_point_index;
    it.point_x     = in_point_x;
    it.point_y     = in_point_y;
    it.wavelength  = in_wavelength;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wp_r] <= it;
    end
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (q_pop) begin
        rp_r <= rp_r + 1'b1;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end

endmodule

// ===== hw/rtl/bti_back.sv =====
module bti_back #(
  parameter int NUM_CURVES = bti_pkg::NumCurvesDef,
  parameter int MAX_POINTS = bti_pkg::MaxPointsDef
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  input  bti_pkg::item_t             q_item,
  output logic                       q_pop,
  input  logic [bti_pkg::CfgW-1:0]   npts [bti_pkg::NumRegs],
  output logic                       out_valid,
  output logic [bti_pkg::YW-1:0]     out_efficiency,
  output logic                       out_in_range
);

  localparam int PW = $clog2(MAX_POINTS);
  localparam int AW = $clog2(NUM_CURVES * MAX_POINTS);
  localparam int DEPTH = NUM_CURVES * MAX_POINTS;
  localparam int NW = $clog2(MAX_POINTS + 1);
  localparam int CW = (NUM_CURVES > 1) ? $clog2(NUM_CURVES) : 1;
  localparam int NUMW = bti_pkg::XW + bti_pkg::YW + 1;

  logic [bti_pkg::XW-1:0] mx [DEPTH];
  logic [bti_pkg::YW-1:0] my [DEPTH];

  bti_pkg::state_t st_r, st_nxt;
  bti_pkg::item_t  cur_r;
  logic [NW-1:0]   n_r;
  logic [PW:0]     i_r;
  logic [AW-1:0]   ra;
  logic [bti_pkg::XW-1:0] rx0_r, rx1_r;
  logic [bti_pkg::YW-1:0] ry0_r, ry1_r;
  logic [bti_pkg::XW-1:0] x0_r, x1_r;
  logic [bti_pkg::YW-1:0] y0_r, y1_r;
  logic                   rd_ok_r;
  logic [NUMW-1:0]        num_r;
  logic                   neg_r;
  logic [bti_pkg::XW-1:0] den_r;
  logic [NUMW-1:0]        quo_r;
  logic [bti_pkg::XW:0]   rem_r;
  logic [5:0]             dc_r;
  logic                   res_ok_r;
  logic [bti_pkg::YW-1:0] res_r;
  logic                   load_ok;
  logic [AW-1:0]          wa;
  logic [7:0]             nraw;
  logic [bti_pkg::XW:0]   rsh;
  logic signed [NUMW+1:0] q;
  logic                   hit;

  assign load_ok = q_item.valid_curve && ({25'd0, q_item.point_index} < MAX_POINTS);
  assign wa = AW'(CW'(q_item.curve) * MAX_POINTS + PW'(q_item.point_index));
  assign q_pop = q_valid && (st_r == bti_pkg::ST_IDLE);
  assign ra = AW'(CW'(cur_r.curve) * MAX_POINTS) + AW'(i_r);
  assign nraw = npts[q_item.curve];
  assign hit = rd_ok_r && (cur_r.wavelength >= rx0_r) && (cur_r.wavelength < rx1_r);
  assign rsh = {rem_r[bti_pkg::XW-1:0], num_r[NUMW-1]};

  always_ff @(posedge clk) begin
    if (q_pop && !q_item.is_query && load_ok) begin
      mx[wa] <= q_item.point_x;
      my[wa] <= q_item.point_y;
    end
    rx0_r <= mx[ra];
    ry0_r <= my[ra];
    rx1_r <= mx[AW'(ra + 1'b1)];
    ry1_r <= my[AW'(ra + 1'b1)];
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      bti_pkg::ST_IDLE: begin
        if (q_valid && q_item.is_query) begin
          st_nxt = bti_pkg::ST_READ;
        end
      end
      bti_pkg::ST_READ: st_nxt = bti_pkg::ST_CHECK;
      bti_pkg::ST_CHECK: begin
        if (hit) begin
          st_nxt = bti_pkg::ST_MUL;
        end else if (!rd_ok_r || ({{(PW+1){1'b0}}, i_r} + 2 >= n_r)) begin
          st_nxt = bti_pkg::ST_DONE;
        end else begin
          st_nxt = bti_pkg::ST_READ;
        end
      end
      bti_pkg::ST_MUL: st_nxt = bti_pkg::ST_DIV;
      bti_pkg::ST_DIV: begin
        if (dc_r == 6'd0) begin
          st_nxt = bti_pkg::ST_DONE;
        end
      end
      bti_pkg::ST_DONE: st_nxt = bti_pkg::ST_IDLE;
      default: st_nxt = bti_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    q = $signed({2'b00, y0_r}) + (neg_r ? -$signed({2'b00, quo_r}) : $signed({2'b00, quo_r}));
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      bti_pkg::ST_IDLE: begin
        cur_r <= q_item;
        i_r   <= '0;
        n_r   <= (nraw > MAX_POINTS) ? NW'(MAX_POINTS) : NW'(nraw);
        res_ok_r <= 1'b0;
        rd_ok_r  <= 1'b0;
      end
      bti_pkg::ST_READ: begin
        rd_ok_r <= cur_r.valid_curve && (n_r >= 2);
      end
      bti_pkg::ST_CHECK: begin
        x0_r <= rx0_r;
        x1_r <= rx1_r;
        y0_r <= ry0_r;
        y1_r <= ry1_r;
        i_r  <= i_r + 1'b1;
      end
      bti_pkg::ST_MUL: begin
        neg_r <= y1_r < y0_r;
        num_r <= NUMW'(cur_r.wavelength - x0_r) *
                 NUMW'((y1_r < y0_r) ? (y0_r - y1_r) : (y1_r - y0_r));
        den_r <= x1_r - x0_r;
        rem_r <= '0;
        dc_r  <= 6'(NUMW - 1);
      end
      bti_pkg::ST_DIV: begin
        if (rsh >= {1'b0, den_r}) begin
          rem_r <= rsh - {1'b0, den_r};
          quo_r <= {quo_r[NUMW-2:0], 1'b1};
        end else begin
          rem_r <= rsh;
          quo_r <= {quo_r[NUMW-2:0], 1'b0};
        end
        num_r <= {num_r[NUMW-2:0], 1'b0};
        dc_r  <= dc_r - 1'b1;
      end
      bti_pkg::ST_DONE: begin
        res_ok_r <= 1'b0;
      end
      default: ;
    endcase
    if (st_r == bti_pkg::ST_DIV && st_nxt == bti_pkg::ST_DONE) begin
      res_ok_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= bti_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      out_valid <= (st_r == bti_pkg::ST_DONE);
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == bti_pkg::ST_DONE) begin
      if (res_ok_r && q > 0) begin
        out_efficiency <= bti_pkg::YW'(q);
        out_in_range   <= 1'b1;
      end else begin
        out_efficiency <= '0;
        out_in_range   <= 1'b0;
      end
    end
  end

endmodule
